// File: rtl/core/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types, codes and decode helpers for the configuration text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ctt_pkg;

    localparam int CharW  = 8;
    localparam int KindW  = 3;
    localparam int ModeW  = 3;
    localparam int CfgIdxW = 3;
    localparam int MaxRes = 3;
    localparam int CntW   = 2;

    // lexer modes
    localparam logic [ModeW-1:0] MODE_BETWEEN   = 3'd0;
    localparam logic [ModeW-1:0] MODE_BARE      = 3'd1;
    localparam logic [ModeW-1:0] MODE_Q_EMPTY   = 3'd2;
    localparam logic [ModeW-1:0] MODE_Q_BODY    = 3'd3;
    localparam logic [ModeW-1:0] MODE_ESC_EMPTY = 3'd4;
    localparam logic [ModeW-1:0] MODE_ESC_BODY  = 3'd5;
    localparam logic [ModeW-1:0] MODE_COMMENT   = 3'd6;

    // token kinds
    localparam logic [KindW-1:0] KIND_CHAR   = 3'd0;
    localparam logic [KindW-1:0] KIND_END    = 3'd1;
    localparam logic [KindW-1:0] KIND_ASSIGN = 3'd2;
    localparam logic [KindW-1:0] KIND_OPEN   = 3'd3;
    localparam logic [KindW-1:0] KIND_CLOSE  = 3'd4;
    localparam logic [KindW-1:0] KIND_LINE   = 3'd5;

    // input command
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_SPACE   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_ASSIGN  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_COMMENT = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_OPEN    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_CLOSE   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_QUOTE   = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_ESCAPE  = 3'd6;

    // register reset values
    localparam logic [CharW-1:0] RST_SPACE   = 8'd32;
    localparam logic [CharW-1:0] RST_ASSIGN  = 8'd61;
    localparam logic [CharW-1:0] RST_COMMENT = 8'd35;
    localparam logic [CharW-1:0] RST_OPEN    = 8'd91;
    localparam logic [CharW-1:0] RST_CLOSE   = 8'd93;
    localparam logic [CharW-1:0] RST_QUOTE   = 8'd34;
    localparam logic [CharW-1:0] RST_ESCAPE  = 8'd92;

    localparam logic [CharW-1:0] TAB_CHAR = 8'd9;

    typedef struct packed {
        logic [CharW-1:0] space_c;
        logic [CharW-1:0] assign_c;
        logic [CharW-1:0] comment_c;
        logic [CharW-1:0] open_c;
        logic [CharW-1:0] close_c;
        logic [CharW-1:0] quote_c;
        logic [CharW-1:0] escape_c;
    } t_cfg;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [CharW-1:0] ch;
        logic             quoted;
    } t_tok;

    typedef struct packed {
        logic             has;
        t_tok             tok;
        logic [ModeW-1:0] mode;
    } t_step;

    function automatic t_tok mk_tok(input logic [KindW-1:0] kind,
                                    input logic [CharW-1:0] ch,
                                    input logic             q);
        t_tok t;
        t.kind   = kind;
        t.ch     = (kind == KIND_CHAR) ? ch : '0;
        t.quoted = q;
        return t;
    endfunction

    // one byte seen between fields
    function automatic t_step between_fn(input logic [CharW-1:0] c, input t_cfg cfg);
        t_step s;
        s.has  = 1'b0;
        s.tok  = mk_tok(KIND_CHAR, '0, 1'b0);
        s.mode = MODE_BETWEEN;
        if (c == cfg.space_c || c == TAB_CHAR) begin
            s.mode = MODE_BETWEEN;
        end else if (c == cfg.assign_c) begin
            s.has = 1'b1;
            s.tok = mk_tok(KIND_ASSIGN, '0, 1'b0);
        end else if (c == cfg.comment_c) begin
            s.mode = MODE_COMMENT;
        end else if (c == cfg.open_c) begin
            s.has = 1'b1;
            s.tok = mk_tok(KIND_OPEN, '0, 1'b0);
        end else if (c == cfg.close_c) begin
            s.has = 1'b1;
            s.tok = mk_tok(KIND_CLOSE, '0, 1'b0);
        end else if (c == cfg.quote_c) begin
            s.mode = MODE_Q_EMPTY;
        end else begin
            s.has  = 1'b1;
            s.tok  = mk_tok(KIND_CHAR, c, 1'b0);
            s.mode = MODE_BARE;
        end
        return s;
    endfunction

    // one byte seen inside quotes
    function automatic t_step quotes_fn(input logic [CharW-1:0] c, input logic nonempty,
                                        input t_cfg cfg);
        t_step s;
        s.has  = 1'b0;
        s.tok  = mk_tok(KIND_END, '0, 1'b1);
        s.mode = MODE_BETWEEN;
        if (c == cfg.quote_c) begin
            s.has  = nonempty;
            s.mode = MODE_BETWEEN;
        end else if (c == cfg.escape_c) begin
            s.mode = nonempty ? MODE_ESC_BODY : MODE_ESC_EMPTY;
        end else begin
            s.has  = 1'b1;
            s.tok  = mk_tok(KIND_CHAR, c, 1'b1);
            s.mode = MODE_Q_BODY;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ctt_cfg_regs.sv
// ----------------------------------------------------------------------------
// ctt_cfg_regs
// Special character registers, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_cfg_regs
    import ctt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr,
    input  wire logic [CfgIdxW-1:0] i_index,
    input  wire logic [CharW-1:0]   i_data,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.space_c   <= RST_SPACE;
            r_cfg.assign_c  <= RST_ASSIGN;
            r_cfg.comment_c <= RST_COMMENT;
            r_cfg.open_c    <= RST_OPEN;
            r_cfg.close_c   <= RST_CLOSE;
            r_cfg.quote_c   <= RST_QUOTE;
            r_cfg.escape_c  <= RST_ESCAPE;
        end else if (i_wr) begin
            case (i_index)
                CFG_SPACE:   r_cfg.space_c   <= i_data;
                CFG_ASSIGN:  r_cfg.assign_c  <= i_data;
                CFG_COMMENT: r_cfg.comment_c <= i_data;
                CFG_OPEN:    r_cfg.open_c    <= i_data;
                CFG_CLOSE:   r_cfg.close_c   <= i_data;
                CFG_QUOTE:   r_cfg.quote_c   <= i_data;
                CFG_ESCAPE:  r_cfg.escape_c  <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/core/ctt_lexer.sv
// ----------------------------------------------------------------------------
// ctt_lexer
// Input register, lexer mode and the decode of one item into up to three tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_lexer
    import ctt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  t_cfg                  i_cfg,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_cmd,
    input  wire logic [CharW-1:0] i_char,
    input  wire logic             i_free,
    output logic                  o_load,
    output t_tok [MaxRes-1:0]     o_tok,
    output logic [CntW-1:0]       o_cnt
);

    logic             r_valid;
    logic             r_cmd;
    logic [CharW-1:0] r_char;
    logic [ModeW-1:0] r_mode;
    logic [ModeW-1:0] n_mode;
    t_tok [MaxRes-1:0] res;
    logic [CntW-1:0]   cnt;
    t_step             st;

    assign o_load  = r_valid && i_free;
    assign o_ready = !r_valid || i_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mode  <= MODE_BETWEEN;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (o_load) begin
                r_mode <= n_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd  <= i_cmd;
            r_char <= i_char;
        end
    end

    always_comb begin
        res    = '0;
        cnt    = '0;
        n_mode = r_mode;
        st     = between_fn(r_char, i_cfg);
        if (r_cmd == CMD_EOL) begin
            n_mode = MODE_BETWEEN;
            case (r_mode)
                MODE_BARE: begin
                    res[0] = mk_tok(KIND_END, '0, 1'b0);
                    res[1] = mk_tok(KIND_LINE, '0, 1'b0);
                    cnt    = 2'd2;
                end
                MODE_Q_BODY: begin
                    res[0] = mk_tok(KIND_END, '0, 1'b1);
                    res[1] = mk_tok(KIND_LINE, '0, 1'b0);
                    cnt    = 2'd2;
                end
                MODE_ESC_EMPTY, MODE_ESC_BODY: begin
                    res[0] = mk_tok(KIND_CHAR, i_cfg.escape_c, 1'b1);
                    res[1] = mk_tok(KIND_END, '0, 1'b1);
                    res[2] = mk_tok(KIND_LINE, '0, 1'b0);
                    cnt    = 2'd3;
                end
                default: begin
                    res[0] = mk_tok(KIND_LINE, '0, 1'b0);
                    cnt    = 2'd1;
                end
            endcase
        end else begin
            case (r_mode)
                MODE_BARE: begin
                    if (r_char == i_cfg.space_c) begin
                        res[0] = mk_tok(KIND_END, '0, 1'b0);
                        cnt    = 2'd1;
                        n_mode = MODE_BETWEEN;
                    end else if (r_char == i_cfg.assign_c || r_char == i_cfg.quote_c ||
                                 r_char == i_cfg.comment_c || r_char == i_cfg.open_c ||
                                 r_char == i_cfg.close_c) begin
                        // field ends, then the special is handled as between fields
                        res[0] = mk_tok(KIND_END, '0, 1'b0);
                        res[1] = st.tok;
                        cnt    = st.has ? 2'd2 : 2'd1;
                        n_mode = st.mode;
                    end else begin
                        res[0] = mk_tok(KIND_CHAR, r_char, 1'b0);
                        cnt    = 2'd1;
                    end
                end
                MODE_Q_EMPTY, MODE_Q_BODY: begin
                    st     = quotes_fn(r_char, r_mode == MODE_Q_BODY, i_cfg);
                    res[0] = st.tok;
                    cnt    = {1'b0, st.has};
                    n_mode = st.mode;
                end
                MODE_ESC_EMPTY, MODE_ESC_BODY: begin
                    if (r_char == i_cfg.quote_c) begin
                        res[0] = mk_tok(KIND_CHAR, i_cfg.quote_c, 1'b1);
                        cnt    = 2'd1;
                        n_mode = MODE_Q_BODY;
                    end else begin
                        // escape not before a quote stays literal
                        st     = quotes_fn(r_char, 1'b1, i_cfg);
                        res[0] = mk_tok(KIND_CHAR, i_cfg.escape_c, 1'b1);
                        res[1] = st.tok;
                        cnt    = st.has ? 2'd2 : 2'd1;
                        n_mode = st.mode;
                    end
                end
                MODE_COMMENT: begin
                    n_mode = MODE_COMMENT;
                end
                default: begin
                    res[0] = st.tok;
                    cnt    = {1'b0, st.has};
                    n_mode = st.mode;
                end
            endcase
        end
    end

    assign o_tok = res;
    assign o_cnt = cnt;

endmodule

`default_nettype wire

// File: rtl/core/ctt_res_buf.sv
// ----------------------------------------------------------------------------
// ctt_res_buf
// Result register holding the tokens of one item, sent one per cycle when ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_res_buf
    import ctt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  t_tok [MaxRes-1:0]     i_tok,
    input  wire logic [CntW-1:0]  i_cnt,
    output logic                  o_free,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_tok                  o_tok,
    output logic                  o_last
);

    logic [CntW-1:0]   r_cnt;
    t_tok [MaxRes-1:0] r_tok;
    logic              pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_last  = (r_cnt == CntW'(1));
    assign o_free  = !o_valid || (o_last && i_ready);
    assign o_tok   = r_tok[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tok <= i_tok;
        end else if (pop) begin
            r_tok[0] <= r_tok[1];
            r_tok[1] <= r_tok[2];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/config_text_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// config_text_tokenizer_unit
// Streaming tokenizer for line-oriented configuration text.
// ----------------------------------------------------------------------------
// One text byte or end-of-line request is taken per cycle unless the input
// register is held. It is decoded in the cycle after it is taken and its
// tokens (zero to three) land in the result register, which sends one token
// per cycle unless m_axis_tready is low, through its single token port; the
// next request waits in the input register meanwhile. The user must write
// special characters over the configuration channel only while the block is
// idle; the block itself does not enforce this.
`default_nettype none

module config_text_tokenizer_unit
    import ctt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CfgIdxW-1:0] i_cfg_index,
    input  wire logic [CharW-1:0]   i_cfg_data,
    // input stream
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [7:0] in_char
    input  wire logic [0:0]         s_axis_tuser,   // [0] cmd
    // token stream
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [7:0]              m_axis_tdata,   // [7:0] out_char
    output logic [3:0]              m_axis_tuser,   // [2:0] kind, [3] quoted
    output logic                    m_axis_tlast
);

    t_cfg              cfg;
    t_tok [MaxRes-1:0] dec_tok;
    logic [CntW-1:0]   dec_cnt;
    logic              load;
    logic              free;
    t_tok              out_tok;

    assign o_cfg_ready = 1'b1;

    ctt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ctt_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (s_axis_tuser[0]),
        .i_char  (s_axis_tdata),
        .i_free  (free),
        .o_load  (load),
        .o_tok   (dec_tok),
        .o_cnt   (dec_cnt)
    );

    ctt_res_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_tok   (dec_tok),
        .i_cnt   (dec_cnt),
        .o_free  (free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tok   (out_tok),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = out_tok.ch;
    assign m_axis_tuser = {out_tok.quoted, out_tok.kind};

endmodule

`default_nettype wire

// File: rtl/core/ctt_checker.sv
// ----------------------------------------------------------------------------
// ctt_checker
// Port-level checks on the token stream of the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_checker
    import ctt_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [3:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // a stalled token holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
        else $error("token changed while stalled");

    // character byte only on field characters
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2:0] != KIND_CHAR) |-> (m_axis_tdata == '0))
        else $error("nonzero character on a non-character token");

    // quoted flag only on field tokens
    a_quoted_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |->
            (m_axis_tuser[2:0] == KIND_CHAR || m_axis_tuser[2:0] == KIND_END))
        else $error("quoted flag on a symbol or line end");

    // line end is always the final token of its request
    a_line_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2:0] == KIND_LINE) |-> m_axis_tlast)
        else $error("line end not marked last");

endmodule

bind config_text_tokenizer_unit ctt_checker u_ctt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
